// ----- design/mkmst_pkg.sv -----
// shared types and constants for the masked kruskal spanning-forest unit
// no dependencies
`timescale 1ns / 1ps

package mkmst_pkg;

  // sizes
  localparam int MAX_NODES   = 16;
  localparam int EDGE_SLOTS  = 120;
  localparam int WEIGHT_BITS = 16;

  localparam int NODE_BITS  = $clog2(MAX_NODES);
  localparam int NCNT_BITS  = $clog2(MAX_NODES + 1);
  localparam int SLOT_BITS  = $clog2(EDGE_SLOTS);
  localparam int SCNT_BITS  = $clog2(EDGE_SLOTS + 1);

  // fixed field widths
  localparam int FIELD_NODE_BITS = 4;
  localparam int FIELD_SLOT_BITS = 7;
  localparam int FIELD_WGT_BITS  = 16;
  localparam int TOTAL_BITS      = 20;
  localparam int JOINED_BITS     = 4;
  localparam int CFG_IDX_BITS    = 1;
  localparam int CFG_DATA_BITS   = 7;

  // edge table entry: src, dest, weight
  localparam int ENTRY_BITS = 2 * FIELD_NODE_BITS + WEIGHT_BITS;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_COUNT = 1'b1;

  // reset values
  localparam logic [4:0] NODE_COUNT_RST = 5'd16;
  localparam logic [6:0] EDGE_COUNT_RST = 7'd120;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } mkmst_state_t;

  // controller to datapath
  typedef struct packed {
    logic                 wr_en;
    logic                 init;
    logic                 rd_en;
    logic [SLOT_BITS-1:0] rd_addr;
  } mkmst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [SCNT_BITS-1:0] scan_len;
  } mkmst_stat_t;

endpackage

// ----- design/masked_kruskal_mst_weight_unit.sv -----
// top level of the masked kruskal spanning-forest weight unit
// depends on mkmst_pkg, mkmst_ctrl and mkmst_dp
`timescale 1ns / 1ps

// Edge-load transactions (in_mode 0) are written into the table while busy stays low,
// so one can follow every cycle. A query transaction (in_mode 1) raises busy
// and scans the edge table one slot per cycle from a single-port memory with
// a registered read, testing each edge against per-node component labels that
// all update in the same cycle on a join. The scan length is edge_count capped
// at 120. After the scan, the last read passes through a drain state, out_valid
// is raised in the done state and busy then drops; no new transaction is
// accepted while busy is high. The result is shown for exactly one
// cycle and cannot be held off. Configuration writes take effect at once and
// should be made only while busy is low.

module masked_kruskal_mst_weight_unit import mkmst_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_mode,
  input  logic [FIELD_SLOT_BITS-1:0] in_edge_slot,
  input  logic [FIELD_NODE_BITS-1:0] in_edge_src,
  input  logic [FIELD_NODE_BITS-1:0] in_edge_dest,
  input  logic [FIELD_WGT_BITS-1:0]  in_edge_weight,
  input  logic [MAX_NODES-1:0]       in_visited_mask,
  output logic                       out_valid,
  output logic [TOTAL_BITS-1:0]      out_tree_weight,
  output logic [JOINED_BITS-1:0]     out_edges_joined,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_wdata
);

  mkmst_cmd_t  cmd;
  mkmst_stat_t stat;

  // sequencer
  mkmst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath
  mkmst_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_edge_slot     (in_edge_slot),
    .in_edge_src      (in_edge_src),
    .in_edge_dest     (in_edge_dest),
    .in_edge_weight   (in_edge_weight),
    .in_visited_mask  (in_visited_mask),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_tree_weight  (out_tree_weight),
    .out_edges_joined (out_edges_joined)
  );

endmodule

// ----- design/mkmst_ctrl.sv -----
// query sequencer for the masked kruskal spanning-forest unit
// depends on mkmst_pkg
`timescale 1ns / 1ps

module mkmst_ctrl import mkmst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        in_mode,
  input  mkmst_stat_t stat,
  output mkmst_cmd_t  cmd,
  output logic        busy,
  output logic        out_valid
);

  mkmst_state_t         state_r, state_nxt;
  logic [SCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 accept;

  assign accept = start && (state_r == ST_IDLE);

  // state and scan counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd.wr_en   = 1'b0;
    cmd.init    = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.rd_addr = cnt_r[SLOT_BITS-1:0];
    out_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_mode == MODE_WRITE) begin
          cmd.wr_en = 1'b1;
        end else if (accept) begin
          cmd.init = 1'b1;
          cnt_nxt  = '0;
          if (stat.scan_len == '0) begin
            state_nxt = ST_DRAIN;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + SCNT_BITS'(1);
        if (cnt_r == stat.scan_len - SCNT_BITS'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTHESIS
  // a query transaction always leaves idle
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_QUERY) |=> busy)
    else $error("query not started");

  // reads stay inside the scanned range
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (SCNT_BITS'(cmd.rd_addr) < stat.scan_len))
    else $error("edge read beyond scan length");

  // one result strobe per query, then idle
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe not followed by idle");
`endif

endmodule

// ----- design/mkmst_dp.sv -----
// edge memory, component labels, accumulators and config registers
// depends on mkmst_pkg
`timescale 1ns / 1ps

module mkmst_dp import mkmst_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mkmst_cmd_t                 cmd,
  output mkmst_stat_t                stat,
  input  logic [FIELD_SLOT_BITS-1:0] in_edge_slot,
  input  logic [FIELD_NODE_BITS-1:0] in_edge_src,
  input  logic [FIELD_NODE_BITS-1:0] in_edge_dest,
  input  logic [FIELD_WGT_BITS-1:0]  in_edge_weight,
  input  logic [MAX_NODES-1:0]       in_visited_mask,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_wdata,
  output logic [TOTAL_BITS-1:0]      out_tree_weight,
  output logic [JOINED_BITS-1:0]     out_edges_joined
);

  logic [ENTRY_BITS-1:0]      edge_mem [EDGE_SLOTS];
  logic [ENTRY_BITS-1:0]      rd_data_r;
  logic                       rd_vld_r;
  logic [4:0]                 node_count_r;
  logic [6:0]                 edge_count_r;
  logic [NCNT_BITS-1:0]       nodes;
  logic [MAX_NODES-1:0]       mask_r;
  logic [NODE_BITS-1:0]       label_r [MAX_NODES];
  logic [TOTAL_BITS-1:0]      total_r, total_nxt;
  logic [JOINED_BITS-1:0]     joined_r, joined_nxt;
  logic [FIELD_NODE_BITS-1:0] ea, eb;
  logic [WEIGHT_BITS-1:0]     ew;
  logic [NODE_BITS-1:0]       la, lb;
  logic                       join_ok;
  logic [TOTAL_BITS:0]        sum;
  logic                       slot_ok;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      edge_count_r <= EDGE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NODE_COUNT: node_count_r <= cfg_wdata[4:0];
        REG_EDGE_COUNT: edge_count_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // saturated node count and scan length
  assign nodes = (int'(node_count_r) > MAX_NODES) ? NCNT_BITS'(MAX_NODES)
                                                 : NCNT_BITS'(node_count_r);
  assign stat.scan_len = (int'(edge_count_r) > EDGE_SLOTS) ? SCNT_BITS'(EDGE_SLOTS)
                                                          : SCNT_BITS'(edge_count_r);

  // edge memory, one write or one registered read a cycle
  assign slot_ok = int'(in_edge_slot) < EDGE_SLOTS;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && slot_ok) begin
      edge_mem[SLOT_BITS'(in_edge_slot)] <= {in_edge_src, in_edge_dest,
                                             in_edge_weight[WEIGHT_BITS-1:0]};
    end
    if (cmd.rd_en) begin
      rd_data_r <= edge_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
    end
  end

  // edge test against labels and mask
  assign ea = rd_data_r[ENTRY_BITS-1 -: FIELD_NODE_BITS];
  assign eb = rd_data_r[WEIGHT_BITS +: FIELD_NODE_BITS];
  assign ew = rd_data_r[WEIGHT_BITS-1:0];
  assign la = label_r[NODE_BITS'(ea)];
  assign lb = label_r[NODE_BITS'(eb)];

  assign join_ok = rd_vld_r
                && (NCNT_BITS'(ea) < nodes) && (NCNT_BITS'(eb) < nodes)
                && !mask_r[NODE_BITS'(ea)] && !mask_r[NODE_BITS'(eb)]
                && (la != lb);

  // saturating accumulators
  assign sum = {1'b0, total_r} + (TOTAL_BITS + 1)'(ew);

  always_comb begin
    total_nxt  = total_r;
    joined_nxt = joined_r;
    if (join_ok) begin
      total_nxt = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
      if (joined_r != '1) begin
        joined_nxt = joined_r + JOINED_BITS'(1);
      end
    end
  end

  // component labels: a join relabels the whole second component at once
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      mask_r   <= in_visited_mask;
      total_r  <= '0;
      joined_r <= '0;
      for (int i = 0; i < MAX_NODES; i++) begin
        label_r[i] <= NODE_BITS'(i);
      end
    end else begin
      total_r  <= total_nxt;
      joined_r <= joined_nxt;
      if (join_ok) begin
        for (int i = 0; i < MAX_NODES; i++) begin
          if (label_r[i] == lb) begin
            label_r[i] <= la;
          end
        end
      end
    end
  end

  assign out_tree_weight  = total_r;
  assign out_edges_joined = joined_r;

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for masked_kruskal_mst_weight_unit: loads edge tables,
// runs masked spanning-forest queries and checks each result against a local predictor
// depends on mkmst_pkg and the masked_kruskal_mst_weight_unit rtl
`timescale 1ns / 1ps

module testbench import mkmst_pkg::*;;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 150;
  localparam int ITEM_TARGET   = 850;

  typedef enum logic {OP_ITEM, OP_CFG} op_kind_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic                      mode;
    logic [6:0]                slot;
    logic [3:0]                src;
    logic [3:0]                dst;
    logic [15:0]               wgt;
    logic [15:0]               vmask;
    logic [CFG_IDX_BITS-1:0]   idx;
    logic [CFG_DATA_BITS-1:0]  data;
    int                        gap;
    bit                        settle;
  } pending_op_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0]  weight;
    logic [JOINED_BITS-1:0] joined;
  } forest_result_t;

  // dut ports
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       in_mode = MODE_WRITE;
  logic [FIELD_SLOT_BITS-1:0] in_edge_slot = '0;
  logic [FIELD_NODE_BITS-1:0] in_edge_src = '0;
  logic [FIELD_NODE_BITS-1:0] in_edge_dest = '0;
  logic [FIELD_WGT_BITS-1:0]  in_edge_weight = '0;
  logic [MAX_NODES-1:0]       in_visited_mask = '0;
  logic                       out_valid;
  logic [TOTAL_BITS-1:0]      out_tree_weight;
  logic [JOINED_BITS-1:0]     out_edges_joined;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_wdata = '0;

  // stimulus and scoreboard state
  pending_op_t    pending_ops[$];
  forest_result_t forest_expect_q[$];
  pending_op_t    cur_op;
  int             gap_left;
  int             idle_run;
  int             mismatch_cnt = 0;
  int             result_cnt = 0;
  int             cycle_cnt = 0;
  int             item_cnt = 0;
  bit             gap_mode = 1'b0;

  // predictor copy of the edge table and registers
  logic [3:0]  tbl_src [EDGE_SLOTS];
  logic [3:0]  tbl_dst [EDGE_SLOTS];
  logic [15:0] tbl_wgt [EDGE_SLOTS];
  logic [4:0]  node_lim;
  logic [6:0]  scan_lim;

  masked_kruskal_mst_weight_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // append to the tail of the stimulus and expectation queues
  task automatic queue_pending(pending_op_t op);
    pending_ops = {pending_ops, op};
  endtask

  task automatic queue_expect(forest_result_t res);
    forest_expect_q = {forest_expect_q, res};
  endtask

  // kruskal over unmasked in-range edges, component labels relabeled on each join
  function automatic forest_result_t predict_forest(logic [15:0] vmask);
    logic [3:0]     comp [MAX_NODES];
    logic [3:0]     a, b, cb;
    int             nodes, scan, total, joined;
    forest_result_t res;
    nodes = (node_lim > MAX_NODES) ? MAX_NODES : node_lim;
    scan = (scan_lim > EDGE_SLOTS) ? EDGE_SLOTS : scan_lim;
    for (int i = 0; i < MAX_NODES; i++) comp[i] = 4'(i);
    total = 0;
    joined = 0;
    for (int k = 0; k < scan; k++) begin
      a = tbl_src[k];
      b = tbl_dst[k];
      if (a >= nodes || b >= nodes) continue;
      if (vmask[a] || vmask[b]) continue;
      if (comp[a] != comp[b]) begin
        cb = comp[b];
        for (int i = 0; i < MAX_NODES; i++)
          if (comp[i] == cb) comp[i] = comp[a];
        total = total + tbl_wgt[k];
        if (total > 20'hFFFFF) total = 20'hFFFFF;
        if (joined < 15) joined++;
      end
    end
    res.weight = TOTAL_BITS'(total);
    res.joined = JOINED_BITS'(joined);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gap_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_mask();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r < 5) return 16'($urandom & $urandom);
    return 16'($urandom & $urandom & $urandom);
  endfunction

  task automatic push_cfg(logic [CFG_IDX_BITS-1:0] idx, int data);
    pending_op_t op;
    op = '0;
    op.kind = OP_CFG;
    op.idx = idx;
    op.data = CFG_DATA_BITS'(data);
    queue_pending(op);
  endtask

  task automatic push_write(int slot, int src, int dst, int wgt);
    pending_op_t op;
    op = '0;
    op.kind = OP_ITEM;
    op.mode = MODE_WRITE;
    op.slot = 7'(slot);
    op.src = 4'(src);
    op.dst = 4'(dst);
    op.wgt = 16'(wgt);
    op.vmask = 16'($urandom);
    op.gap = pick_gap();
    queue_pending(op);
    if (slot < EDGE_SLOTS) item_cnt++;
  endtask

  task automatic push_query(logic [15:0] vmask);
    pending_op_t op;
    op = '0;
    op.kind = OP_ITEM;
    op.mode = MODE_QUERY;
    op.slot = 7'($urandom);
    op.src = 4'($urandom);
    op.dst = 4'($urandom);
    op.wgt = 16'($urandom);
    op.vmask = vmask;
    op.gap = pick_gap();
    op.settle = ($urandom_range(0, 19) == 0);
    queue_pending(op);
    item_cnt++;
  endtask

  // one phase: set both registers, load an ascending edge list, then query it
  task automatic run_phase(int nc, int ec);
    int n_load, step, wt, eff, a, b, r;
    push_cfg(REG_NODE_COUNT, nc);
    push_cfg(REG_EDGE_COUNT, ec);
    n_load = (ec > EDGE_SLOTS) ? EDGE_SLOTS : ec;
    step = (n_load > 0) ? 131070 / n_load : 1;
    eff = (nc == 0 || nc > MAX_NODES) ? MAX_NODES : nc;
    wt = 0;
    for (int s = 0; s < n_load; s++) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        a = $urandom_range(0, 15);
        b = $urandom_range(0, 15);
      end else if (r == 1 || eff < 2) begin
        a = $urandom_range(0, eff - 1);
        b = a;
      end else begin
        a = $urandom_range(0, eff - 1);
        b = $urandom_range(0, eff - 2);
        if (b >= a) b++;
      end
      wt = wt + $urandom_range(0, step);
      if (wt > 65535) wt = 65535;
      push_write(s, a, b, wt);
      // out-of-range slot writes are noise the block must drop
      if ($urandom_range(0, 29) == 0)
        push_write($urandom_range(EDGE_SLOTS, 127), $urandom, $urandom, $urandom);
    end
    repeat ($urandom_range(3, 6)) push_query(pick_mask());
  endtask

  // driver: one transaction or register write per edge, predictor updated on acceptance
  always @(posedge clk) begin
    pending_op_t op;
    logic        nx_start;
    logic        nx_we;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      gap_left = 0;
      idle_run = 0;
      node_lim = NODE_COUNT_RST;
      scan_lim = EDGE_COUNT_RST;
    end else begin
      nx_start = start;
      nx_we = 1'b0;
      if (start && !busy) begin
        if (cur_op.mode == MODE_WRITE) begin
          if (cur_op.slot < EDGE_SLOTS) begin
            tbl_src[cur_op.slot] = cur_op.src;
            tbl_dst[cur_op.slot] = cur_op.dst;
            tbl_wgt[cur_op.slot] = cur_op.wgt;
          end
        end else begin
          queue_expect(predict_forest(cur_op.vmask));
        end
        nx_start = 1'b0;
        gap_left = cur_op.gap;
      end
      if (forest_expect_q.size() == 0 && !busy && !start) idle_run++;
      else idle_run = 0;
      if (!nx_start && pending_ops.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          op = pending_ops[0];
          if (op.kind == OP_CFG) begin
            // register writes only once the block has gone quiet
            if (idle_run >= SETTLE_CYCLES) begin
              nx_we = 1'b1;
              cfg_index <= op.idx;
              cfg_wdata <= op.data;
              if (op.idx == REG_NODE_COUNT) node_lim = op.data[4:0];
              else scan_lim = op.data[6:0];
              void'(pending_ops.pop_front());
            end
          end else if (!op.settle || idle_run >= SETTLE_CYCLES) begin
            nx_start = 1'b1;
            in_mode <= op.mode;
            in_edge_slot <= op.slot;
            in_edge_src <= op.src;
            in_edge_dest <= op.dst;
            in_edge_weight <= op.wgt;
            in_visited_mask <= op.vmask;
            cur_op = op;
            void'(pending_ops.pop_front());
          end
        end
      end
      start <= nx_start;
      cfg_we <= nx_we;
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    forest_result_t want;
    if (rst_n && out_valid) begin
      if (forest_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: tree_weight %0d edges_joined %0d",
                   out_tree_weight, out_edges_joined);
      end else begin
        want = forest_expect_q.pop_front();
        if (out_tree_weight !== want.weight || out_edges_joined !== want.joined) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: expected weight %0d joined %0d, got weight %0d joined %0d",
                     result_cnt, want.weight, want.joined, out_tree_weight,
                     out_edges_joined);
        end
        result_cnt++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** masked_kruskal_mst_weight_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int phase, nc, ec, r;

    // directed: small table, weight extremes, self loop, masks and register corners
    push_cfg(REG_EDGE_COUNT, 3);
    push_cfg(REG_NODE_COUNT, 16);
    push_write(0, 0, 1, 0);
    push_write(1, 15, 14, 16'hFFFF);
    push_write(2, 3, 3, 16'hFFFF);
    push_query(16'h0000);
    push_query(16'hFFFF);
    push_query(16'h0002);
    push_query(16'h8000);
    push_write(EDGE_SLOTS, 1, 2, 5);
    push_write(127, 2, 3, 6);
    push_write(2, 1, 15, 16'hFFFF);
    push_query(16'h0000);
    push_cfg(REG_NODE_COUNT, 2);
    push_query(16'h0000);
    push_cfg(REG_NODE_COUNT, 0);
    push_query(16'h0000);
    push_cfg(REG_NODE_COUNT, 7'h7F);
    push_query(16'h0000);
    push_cfg(REG_NODE_COUNT, 17);
    push_query(16'h4000);
    push_cfg(REG_NODE_COUNT, 1);
    push_query(16'h0000);
    push_cfg(REG_EDGE_COUNT, 0);
    push_query(16'h0000);

    // random phases, every sixth a full table on all nodes
    phase = 0;
    while (item_cnt < ITEM_TARGET) begin
      gap_mode = ($urandom_range(0, 3) != 0);
      if (phase % 6 == 0) begin
        nc = 16;
        ec = ($urandom_range(0, 1) != 0) ? EDGE_SLOTS : 127;
      end else begin
        r = $urandom_range(0, 11);
        if (r == 0) nc = 0;
        else if (r == 1) nc = $urandom_range(17, 31);
        else if (r == 2) nc = 1;
        else nc = $urandom_range(2, 16);
        ec = $urandom_range(0, 40);
      end
      run_phase(nc, ec);
      phase++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || start) @(posedge clk);
    while (forest_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && forest_expect_q.size() == 0)
      $display("** masked_kruskal_mst_weight_unit: PASSED **");
    else
      $display("** masked_kruskal_mst_weight_unit: FAILED **");
    $finish;
  end

endmodule
